// ===== hw/rtl/macd_pkg.sv =====
package macd_pkg;

    // Fixed field widths of the stream words
    localparam int PRICE_BITS = 32;
    localparam int VAL_BITS   = 32;
    localparam int Q_FRAC     = 16;

    // Defaults for the top-level parameters
    localparam int ACC_BITS_DEF    = 48;
    localparam int PERIOD_BITS_DEF = 8;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAST   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SLOW   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGNAL = 2'd2;

    localparam int FAST_RESET   = 12;
    localparam int SLOW_RESET   = 26;
    localparam int SIGNAL_RESET = 9;

    // Average lanes, also the accumulator index
    localparam logic [1:0] LANE_FAST = 2'd0;
    localparam logic [1:0] LANE_SLOW = 2'd1;
    localparam logic [1:0] LANE_SIG  = 2'd2;

    typedef struct packed {
        logic signed [PRICE_BITS-1:0] price;
        logic                         price_valid;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] macd_line;
        logic signed [VAL_BITS-1:0] signal_value;
        logic signed [VAL_BITS-1:0] histogram_value;
        logic                       result_valid;
    } out_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic [1:0] lane;
        logic       acc_add;
        logic       seed_start;
        logic       ema_start;
        logic       macd_load;
        logic       out_load;
        logic       res_valid;
    } dp_cmd_t;

endpackage

// ===== hw/rtl/macd_div.sv =====
module macd_div
    import macd_pkg::*;
#(
    parameter int DW = 65,
    parameter int DV = 9
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [DV-1:0]        divisor,
    output logic                 done,
    output logic [DW-1:0]        quotient
);

    localparam int CNT_BITS = $clog2(DW + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                neg_reg, neg_next;
    logic [DW-1:0]       work_reg, work_next;
    logic [DV-1:0]       rem_reg, rem_next;
    logic [DV-1:0]       dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DV:0]         trial;
    logic [DV:0]         diff;
    logic                ge;

    // floor division: negative dividend a gives ~(~a / d)
    assign trial = {rem_reg, work_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[DW-1];
            work_next = dividend[DW-1] ? ~dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_BITS'(DW);
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DV-1:0] : trial[DV-1:0];
            work_next = {work_reg[DW-2:0], ge};
            cnt_next  = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? ~work_reg : work_reg;

endmodule

// ===== hw/rtl/macd_dp.sv =====
module macd_dp
    import macd_pkg::*;
#(
    parameter int ACC_BITS    = ACC_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic signed [PRICE_BITS-1:0] price_in,
    input  logic [PERIOD_BITS-1:0]       period,
    output logic                         div_done,
    output out_word_t                    out_data
);

    localparam int XW  = VAL_BITS + Q_FRAC;
    localparam int DWS = ACC_BITS + Q_FRAC + 1;
    localparam int DWE = ((XW > ACC_BITS) ? XW : ACC_BITS) + 3;
    localparam int DW  = (DWS > DWE) ? DWS : DWE;
    localparam int DV  = PERIOD_BITS + 1;
    localparam int SW  = ACC_BITS + 2;

    logic signed [ACC_BITS-1:0]   acc_reg [3];
    logic signed [PRICE_BITS-1:0] price_reg;
    logic signed [VAL_BITS-1:0]   macd_reg;
    out_word_t                    out_reg;
    logic                         ema_reg;
    logic [1:0]                   wb_lane_reg;

    logic signed [ACC_BITS-1:0] acc_sel;
    logic signed [VAL_BITS-1:0] x_in;
    logic signed [DW-1:0]       seed_dvd;
    logic signed [DW-1:0]       ema_dvd;
    logic signed [DW-1:0]       dvd;
    logic [DV-1:0]              dvs;
    logic [DV-1:0]              half;
    logic [DW-1:0]              quot;
    logic signed [VAL_BITS-1:0] macd_q;
    logic signed [VAL_BITS-1:0] sig_q;
    logic signed [VAL_BITS:0]   hist_w;
    logic signed [VAL_BITS-1:0] hist_q;

    // Q16.32 to Q16.16 with round half up and saturation
    function automatic logic signed [VAL_BITS-1:0] q16_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]         r;
        logic [SW-VAL_BITS:0]         hi;
        r  = (v + SW'(32'sd32768)) >>> Q_FRAC;
        hi = r[SW-1:VAL_BITS-1];
        if (hi == '0 || hi == '1)
            return r[VAL_BITS-1:0];
        else
            return r[SW-1] ? {1'b1, {(VAL_BITS-1){1'b0}}} : {1'b0, {(VAL_BITS-1){1'b1}}};
    endfunction

    assign acc_sel = acc_reg[cmd.lane];
    assign x_in    = (cmd.lane == LANE_SIG) ? macd_reg : price_reg;

    // seed: floor((sum << 16 + n/2) / n); update: floor((2(x - e) + (n+1)/2) / (n+1))
    assign dvs      = cmd.seed_start ? DV'(period) : DV'(period) + DV'(1);
    assign half     = dvs >> 1;
    assign seed_dvd = (DW'(acc_sel) <<< Q_FRAC) + DW'(half);
    assign ema_dvd  = (((DW'(x_in) <<< Q_FRAC) - DW'(acc_sel)) <<< 1) + DW'(half);
    assign dvd      = cmd.seed_start ? seed_dvd : ema_dvd;

    macd_div #(
        .DW (DW),
        .DV (DV)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.seed_start | cmd.ema_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quot)
    );

    assign macd_q = q16_sat(SW'(acc_reg[LANE_FAST]) - SW'(acc_reg[LANE_SLOW]));
    assign sig_q  = q16_sat(SW'(acc_reg[LANE_SIG]));
    assign hist_w = (VAL_BITS+1)'(macd_reg) - (VAL_BITS+1)'(sig_q);
    assign hist_q = (hist_w[VAL_BITS] == hist_w[VAL_BITS-1]) ? hist_w[VAL_BITS-1:0] :
                    (hist_w[VAL_BITS] ? {1'b1, {(VAL_BITS-1){1'b0}}}
                                      : {1'b0, {(VAL_BITS-1){1'b1}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (div_done)
        begin
            acc_reg[wb_lane_reg] <= ema_reg ? acc_reg[wb_lane_reg] + quot[ACC_BITS-1:0]
                                            : quot[ACC_BITS-1:0];
        end
        else if (cmd.acc_add)
        begin
            acc_reg[cmd.lane] <= acc_sel + ACC_BITS'(x_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            price_reg <= price_in;
        if (cmd.seed_start || cmd.ema_start)
        begin
            ema_reg     <= cmd.ema_start;
            wb_lane_reg <= cmd.lane;
        end
        if (cmd.macd_load)
            macd_reg <= macd_q;
        if (cmd.out_load)
        begin
            if (cmd.res_valid)
            begin
                out_reg.macd_line       <= macd_reg;
                out_reg.signal_value    <= sig_q;
                out_reg.histogram_value <= hist_q;
                out_reg.result_valid    <= 1'b1;
            end
            else
            begin
                out_reg <= '0;
            end
        end
    end

    assign out_data = out_reg;

endmodule

// ===== hw/rtl/macd_ctrl.sv =====
module macd_ctrl
    import macd_pkg::*;
#(
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    price_valid,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]  cfg_data,
    input  logic                    div_done,
    output dp_cmd_t                 cmd,
    output logic [PERIOD_BITS-1:0]  period
);

    localparam int PB = PERIOD_BITS;
    localparam int CW = PB + 1;
    localparam int WW = PB + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LANE = 3'd1;
    localparam logic [2:0] S_SEED = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_MACD = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    lane_reg, lane_next;
    logic          res_valid_reg, res_valid_next;
    logic          ok_reg, ok_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PB-1:0] fast_reg, slow_reg, sig_reg;

    logic [PB-1:0] f, s, g, m;
    logic [WW-1:0] lim, c1, pos, n_w;
    logic          macd_on, val_on, below, last;

    assign f   = (fast_reg == '0) ? PB'(1) : fast_reg;
    assign s   = (slow_reg == '0) ? PB'(1) : slow_reg;
    assign g   = (sig_reg  == '0) ? PB'(1) : sig_reg;
    assign m   = (f > s) ? f : s;
    assign lim = WW'(m) + WW'(g) - WW'(1);
    assign c1  = WW'(count_reg) + WW'(1);

    assign macd_on = (c1 >= WW'(m));
    assign val_on  = (c1 >= lim);

    always_comb
    begin
        unique case (lane_reg)
            LANE_FAST: period = f;
            LANE_SLOW: period = s;
            default:   period = g;
        endcase
    end

    // position inside the lane: sample count, or MACD count for the signal
    assign pos   = (lane_reg == LANE_SIG) ? c1 - WW'(m) : WW'(count_reg);
    assign n_w   = WW'(period);
    assign below = (pos < n_w);
    assign last  = (pos == n_w - WW'(1));

    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        res_valid_next = res_valid_reg;
        ok_next        = ok_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.lane       = lane_reg;
        cmd.res_valid  = res_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    ok_next     = price_valid;
                    lane_next   = LANE_FAST;
                    if (price_valid)
                    begin
                        state_next = S_LANE;
                    end
                    else
                    begin
                        res_valid_next = 1'b0;
                        state_next     = S_OUT;
                    end
                end
            end
            S_LANE, S_WAIT:
            begin
                priority if (state_reg == S_LANE && !below)
                begin
                    cmd.ema_start = 1'b1;
                    state_next    = S_WAIT;
                end
                else if (state_reg == S_LANE && last)
                begin
                    cmd.acc_add = 1'b1;
                    state_next  = S_SEED;
                end
                else if (state_reg == S_WAIT && !div_done)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.acc_add = (state_reg == S_LANE);
                    // lane finished: step to the next lane, or on to the output
                    unique case (lane_reg)
                        LANE_FAST:
                        begin
                            lane_next  = LANE_SLOW;
                            state_next = S_LANE;
                        end
                        LANE_SLOW:
                        begin
                            res_valid_next = 1'b0;
                            state_next     = macd_on ? S_MACD : S_OUT;
                        end
                        default:
                        begin
                            res_valid_next = val_on;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_SEED:
            begin
                cmd.seed_start = 1'b1;
                state_next     = S_WAIT;
            end
            S_MACD:
            begin
                cmd.macd_load = 1'b1;
                lane_next     = LANE_SIG;
                state_next    = S_LANE;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    if (ok_reg && (WW'(count_reg) < lim))
                        count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= LANE_FAST;
            res_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            fast_reg      <= PB'(FAST_RESET);
            slow_reg      <= PB'(SLOW_RESET);
            sig_reg       <= PB'(SIGNAL_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            res_valid_reg <= res_valid_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FAST:   fast_reg <= cfg_data;
                    REG_SLOW:   slow_reg <= cfg_data;
                    REG_SIGNAL: sig_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/macd_indicator_stream_core.sv =====
// MACD indicator on a stream of signed Q16.16 prices. Each input word gives
// one output word. A word with price_valid low is dropped from the averages
// and answers all zeros. The fast and slow averages are seeded with the mean
// of their first N prices and then track with alpha = 2/(N+1); the signal
// average runs the same way over the MACD values. Outputs stay zero with
// result_valid low until max(fast,slow)+signal-1 valid prices were taken.
// Periods (registers 0 fast, 1 slow, 2 signal; 0 acts as 1) are to be written
// only while the block is idle; the user must keep to this, the block itself
// does not enforce it. The block takes one word at a time. Each average that
// seeds or updates runs one serial division of DW = max(ACC_BITS+17, 51) bits
// on the shared radix-2 divider: an update runs a start, DW shift steps and a
// done, and a seed first adds the last sum. A word passes the accept, the
// divisions of its lanes, the MACD load when due and the output step, plus any
// output stall. An output register holds a finished word, so the next price is
// taken while it waits.
module macd_indicator_stream_core
    import macd_pkg::*;
#(
    parameter int ACC_BITS    = ACC_BITS_DEF,
    parameter int PERIOD_BITS = PERIOD_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_word_t                in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_word_t               out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [PERIOD_BITS-1:0]  cfg_data
);

    dp_cmd_t                 cmd;
    logic [PERIOD_BITS-1:0]  period;
    logic                    div_done;

    // sequencer: config registers, sample count, phase decisions
    macd_ctrl #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .price_valid (in_data.price_valid),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .div_done    (div_done),
        .cmd         (cmd),
        .period      (period)
    );

    // accumulators, shared divider, output word register
    macd_dp #(
        .ACC_BITS    (ACC_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .price_in (in_data.price),
        .period   (period),
        .div_done (div_done),
        .out_data (out_data)
    );

endmodule

// ===== sim/macd_checker.sv =====
module macd_checker
    import macd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  in_word_t                in_data,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  out_word_t               out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]              cfg_data,
    output int                      errors,
    output int                      pending
);

    localparam int ACC_W = 48;

    out_word_t macd_words_due[$];

    int     fast_len, slow_len, sig_len;
    int     valid_count;
    longint fast_avg, slow_avg, sig_avg;

    function automatic longint wrap48(longint v);
        return (v <<< (64 - ACC_W)) >>> (64 - ACC_W);
    endfunction

    function automatic longint fdiv(longint a, longint b);
        if (a >= 0)
            return a / b;
        return -((-(a + 1)) / b) - 1;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint to_q16(longint v);
        return sat32(fdiv(v + 32768, 65536));
    endfunction

    function automatic longint seed_mean(longint sum, int n);
        longint q, r, frac;
        q    = fdiv(sum, n);
        r    = sum - q * n;
        frac = (r * 65536 + n / 2) / n;
        return wrap48(q * 65536 + frac);
    endfunction

    function automatic longint ema_step(longint e, longint x, int n);
        longint num;
        num = 2 * (x - e) + (n + 1) / 2;
        return wrap48(e + fdiv(num, n + 1));
    endfunction

    // running sum until seeded, then the average itself in Q16.32
    function automatic longint track_avg(longint acc, longint x, int c, int n);
        if (c < n) begin
            acc = wrap48(acc + x);
            if (c == n - 1)
                acc = seed_mean(acc, n);
            return acc;
        end
        return ema_step(acc, x * 65536, n);
    endfunction

    function automatic out_word_t macd_next(in_word_t w);
        out_word_t r;
        int        f, s, g, m, lim, c, k;
        longint    macd, sg;
        r = '0;
        if (!w.price_valid)
            return r;
        f   = (fast_len == 0) ? 1 : fast_len;
        s   = (slow_len == 0) ? 1 : slow_len;
        g   = (sig_len == 0) ? 1 : sig_len;
        m   = (f > s) ? f : s;
        lim = m + g - 1;
        c   = valid_count;
        fast_avg = track_avg(fast_avg, longint'(w.price), c, f);
        slow_avg = track_avg(slow_avg, longint'(w.price), c, s);
        if (c + 1 >= m) begin
            k    = c + 1 - m;
            macd = to_q16(fast_avg - slow_avg);
            if (k < g) begin
                sig_avg = wrap48(sig_avg + macd);
                if (k == g - 1)
                    sig_avg = seed_mean(sig_avg, g);
            end else begin
                sig_avg = ema_step(sig_avg, macd * 65536, g);
            end
            if (c + 1 >= lim) begin
                sg                = to_q16(sig_avg);
                r.macd_line       = macd[31:0];
                r.signal_value    = sg[31:0];
                r.histogram_value = 32'(sat32(macd - sg));
                r.result_valid    = 1'b1;
            end
        end
        if (c < lim)
            valid_count = c + 1;
        return r;
    endfunction

    assign pending = macd_words_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n) begin
            fast_len    = FAST_RESET;
            slow_len    = SLOW_RESET;
            sig_len     = SIGNAL_RESET;
            valid_count = 0;
            fast_avg    = 0;
            slow_avg    = 0;
            sig_avg     = 0;
            errors      = 0;
            macd_words_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FAST:   fast_len = cfg_data;
                    REG_SLOW:   slow_len = cfg_data;
                    REG_SIGNAL: sig_len  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                macd_words_due = {macd_words_due, macd_next(in_data)};
            if (out_valid && out_ready) begin
                if (macd_words_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, out_data);
                end else begin
                    exp_w = macd_words_due.pop_front();
                    if (out_data.macd_line !== exp_w.macd_line) begin
                        errors++;
                        $display("%0t: macd exp %h got %h", $time,
                                 exp_w.macd_line, out_data.macd_line);
                    end
                    if (out_data.signal_value !== exp_w.signal_value) begin
                        errors++;
                        $display("%0t: signal exp %h got %h", $time,
                                 exp_w.signal_value, out_data.signal_value);
                    end
                    if (out_data.histogram_value !== exp_w.histogram_value) begin
                        errors++;
                        $display("%0t: hist exp %h got %h", $time,
                                 exp_w.histogram_value, out_data.histogram_value);
                    end
                    if (out_data.result_valid !== exp_w.result_valid) begin
                        errors++;
                        $display("%0t: valid exp %b got %b", $time,
                                 exp_w.result_valid, out_data.result_valid);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_macd_indicator_stream_core.sv =====
module tb_macd_indicator_stream_core;
    import macd_pkg::*;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_word_t                in_data;
    logic                    out_valid;
    logic                    out_ready;
    out_word_t               out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [7:0]              cfg_data;
    int                      errors;
    int                      pending;

    // idle percentages, changed between stimulus thirds
    int send_idle_pct;
    int recv_idle_pct;
    int price_level;

    macd_indicator_stream_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    macd_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver side backpressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // offer one word; valid holds until the handshake
    task automatic send_word(input logic signed [31:0] price, input logic pv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        in_data.price       <= price;
        in_data.price_valid <= pv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // config writes only with nothing in flight
    task automatic set_periods(input int f, input int s, input int g);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FAST;
        cfg_data  <= 8'(f);
        @(negedge clk);
        cfg_index <= REG_SLOW;
        cfg_data  <= 8'(s);
        @(negedge clk);
        cfg_index <= REG_SIGNAL;
        cfg_data  <= 8'(g);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly a drifting market, sometimes wild or extreme values
    task automatic send_random_price();
        logic signed [31:0] p;
        case ($urandom_range(0, 9))
            0, 1: p = $urandom;
            2:    p = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default:
            begin
                price_level = price_level + $signed($urandom_range(0, 65536 * 8))
                              - 65536 * 4;
                p = price_level;
            end
        endcase
        send_word(p, $urandom_range(0, 9) != 0);
    endtask

    initial
    begin
        int n;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FAST;
        cfg_data      = '0;
        send_idle_pct = 34;
        recv_idle_pct = 54;
        price_level   = 100 * 65536;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes and NaN words at reset periods
        send_word(32'sh00000000, 1'b1);
        send_word(32'sh7fffffff, 1'b1);
        send_word(32'sh80000000, 1'b1);
        send_word(32'sh7fffffff, 1'b0);
        send_word(32'shffffffff, 1'b1);
        send_word(32'sh00000001, 1'b1);
        send_word(32'sh00010000, 1'b1);
        send_word(32'shffff0000, 1'b0);

        // directed: unit, zero and 255 periods, big swings drive saturation
        set_periods(1, 1, 1);
        send_word(32'sh7fffffff, 1'b1);
        send_word(32'sh80000000, 1'b1);
        set_periods(1, 255, 1);
        send_word(32'sh7fffffff, 1'b1);
        send_word(32'sh80000000, 1'b1);
        send_word(32'sh7fffffff, 1'b1);
        set_periods(0, 0, 0);
        send_word(32'sh80000000, 1'b1);
        send_word(32'sh00000000, 1'b0);
        send_word(32'sh7fffffff, 1'b1);

        // random phases over assorted period settings
        for (n = 0; n < 1350; n++) begin
            if (n == 450) begin
                send_idle_pct = 54;
                recv_idle_pct = 34;
            end
            if (n == 900) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (n)
                0:    set_periods(12, 26, 9);
                200:  set_periods(2, 5, 3);
                350:  set_periods(255, 3, 2);
                650:  set_periods(0, 1, 255);
                800:  set_periods(7, 4, 1);
                1000: set_periods(255, 255, 255);
                1100: set_periods($urandom_range(1, 8), $urandom_range(1, 8),
                                  $urandom_range(1, 8));
                default: ;
            endcase
            send_random_price();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/macd_pkg.sv
hw/rtl/macd_div.sv
hw/rtl/macd_dp.sv
hw/rtl/macd_ctrl.sv
hw/rtl/macd_indicator_stream_core.sv
sim/macd_checker.sv
sim/tb_macd_indicator_stream_core.sv
